FILE: src/tbs_pkg.sv
// Shared types and codes for the token bucket packet shaper.
`default_nettype none

package tbs_pkg;

    typedef enum logic [2:0] {
        ST_RELEASED      = 3'd0,
        ST_QUEUED        = 3'd1,
        ST_TOO_LARGE     = 3'd2,
        ST_QUEUE_FULL    = 3'd3,
        ST_TOKEN_ADDED   = 3'd4,
        ST_TOKEN_DROPPED = 3'd5
    } t_status;

    typedef enum logic {
        MODE_ARRIVAL = 1'b0,
        MODE_TICK    = 1'b1
    } t_mode;

    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_CHECK = 1'b1
    } t_fsm;

    typedef struct packed {
        logic        mode;
        logic [31:0] packet_id;
        logic [15:0] tokens_needed;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] result_packet_id;
        logic [15:0] tokens_left;
        logic        last;
    } t_out;

    // One waiting packet as it is kept in the queue memory.
    typedef struct packed {
        logic [31:0] id;
        logic [15:0] need;
    } t_entry;

    localparam logic [15:0] DEPTH_RESET = 16'd10;

endpackage

`default_nettype wire

FILE: src/tbs_wait_ram.sv
// Simple dual port queue memory with a registered read port.
`default_nettype none

module tbs_wait_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [ADDR_W-1:0]     i_wr_addr,
    input  wire tbs_pkg::t_entry i_wr_data,
    input  wire [ADDR_W-1:0]     i_rd_addr,
    output tbs_pkg::t_entry      o_rd_data
);

    tbs_pkg::t_entry r_mem [DEPTH];
    tbs_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read returns the contents before any write in the same cycle.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: src/token_bucket_packet_shaper_top.sv
// Top level of the token bucket packet shaper with its waiting packet queue.
// An arrival gives its one result in the cycle after it is accepted, and busy stays low.
// A tick's result passes the held and output registers, then one release per cycle follows;
// busy stays high until the final result, the queue memory being read at the next head.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset clears the token count, queue pointers and fill count and sets the depth to 10.
`default_nettype none

module token_bucket_packet_shaper_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire tbs_pkg::t_in i_item,
    output logic              o_result_valid,
    output tbs_pkg::t_out     o_result,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [15:0]        i_cfg_data
);

    // Pointer width stays at least one bit so that a single-entry queue still has an address.
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    // Control state.
    tbs_pkg::t_fsm     r_state, n_state;
    logic [15:0]       r_depth;
    logic [15:0]       r_tokens, n_tokens;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // Payload state: the result on the ports and the one held back until we know
    // whether it is the last of its tick.
    tbs_pkg::t_out     r_out, n_out;
    tbs_pkg::t_out     r_pend, n_pend;

    // Queue memory interface.
    logic              wr_en;
    tbs_pkg::t_entry   wr_data;
    tbs_pkg::t_entry   rd_data;

    logic              accept;
    logic              can_release;

    assign accept      = start && (r_state == tbs_pkg::FSM_IDLE);
    assign busy        = (r_state != tbs_pkg::FSM_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result    = r_out;

    assign wr_data.id   = i_item.packet_id;
    assign wr_data.need = i_item.tokens_needed;

    // The memory is always read at the next head, so its output holds the
    // current head entry, except right after a packet joins an empty queue.
    tbs_wait_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_wait_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (wr_data),
        .i_rd_addr (n_head),
        .o_rd_data (rd_data)
    );

    // A head packet may leave once the bucket covers its need.
    assign can_release = (r_count != '0) && (r_tokens >= rd_data.need);

    always_comb begin
        n_state     = r_state;
        n_tokens    = r_tokens;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_pend      = r_pend;
        wr_en       = 1'b0;

        case (r_state)
            tbs_pkg::FSM_IDLE: begin
                if (accept && (i_item.mode == tbs_pkg::MODE_ARRIVAL)) begin
                    // An arrival settles in the cycle it is taken and gives one result.
                    n_out_valid            = 1'b1;
                    n_out.result_packet_id = i_item.packet_id;
                    n_out.last             = 1'b1;
                    if (i_item.tokens_needed > r_depth) begin
                        n_out.status = tbs_pkg::ST_TOO_LARGE;
                    end else if (r_count == FULL_CNT) begin
                        n_out.status = tbs_pkg::ST_QUEUE_FULL;
                    end else if ((r_count == '0) && (r_tokens >= i_item.tokens_needed)) begin
                        n_out.status = tbs_pkg::ST_RELEASED;
                        n_tokens     = r_tokens - i_item.tokens_needed;
                    end else begin
                        // Packets already waiting keep their order, so this one joins the tail.
                        n_out.status = tbs_pkg::ST_QUEUED;
                        wr_en        = 1'b1;
                        n_tail       = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                    n_out.tokens_left = n_tokens;
                end else if (accept) begin
                    // A tick adds a token unless the bucket is already at or above depth.
                    if (r_tokens < r_depth) begin
                        n_tokens      = r_tokens + 16'd1;
                        n_pend.status = tbs_pkg::ST_TOKEN_ADDED;
                    end else begin
                        n_pend.status = tbs_pkg::ST_TOKEN_DROPPED;
                    end
                    n_pend.result_packet_id = '0;
                    n_pend.tokens_left      = n_tokens;
                    n_pend.last             = 1'b0;
                    n_state                 = tbs_pkg::FSM_CHECK;
                end
            end
            tbs_pkg::FSM_CHECK: begin
                // The held result goes out now; it is last unless the head packet leaves too.
                n_out_valid = 1'b1;
                n_out       = r_pend;
                n_out.last  = !can_release;
                if (can_release) begin
                    n_tokens                = r_tokens - rd_data.need;
                    n_head                  = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                    n_count                 = r_count - 1'b1;
                    n_pend.status           = tbs_pkg::ST_RELEASED;
                    n_pend.result_packet_id = rd_data.id;
                    n_pend.tokens_left      = n_tokens;
                    n_pend.last             = 1'b0;
                end else begin
                    n_state = tbs_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = tbs_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbs_pkg::FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= tbs_pkg::DEPTH_RESET;
            r_tokens    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_depth <= i_cfg_data;
            end
            r_tokens    <= n_tokens;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill count above depth");

    // An empty queue has its head and tail on the same slot.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with split pointers");

    // An accepted arrival gives a final result in the next cycle.
    a_arrival_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.mode == tbs_pkg::MODE_ARRIVAL))
        |=> (o_result_valid && o_result.last))
        else $error("arrival without a single final result");

    // Every release scan cycle puts out a result.
    a_check_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbs_pkg::FSM_CHECK) |=> o_result_valid)
        else $error("release scan cycle without a result");

    // Busy drops only together with the final result of a tick.
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_result_valid && o_result.last))
        else $error("busy dropped without a final result");

endmodule

`default_nettype wire
